### rtl/gstc_pkg.sv
// Package: shared types, constants and sequencer states for the stick conditioner.
package gstc_pkg;

  localparam int unsigned AxisFullScale = 32767;
  localparam int unsigned OutFullScale  = 127;
  localparam logic [23:0] MagMax        = 24'hFFFFFF;
  localparam logic [23:0] FullQ         = 24'(AxisFullScale * 256);
  localparam logic [23:0] OutLimQ       = 24'(OutFullScale * 256);
  localparam logic [15:0] ScaleNum      = 16'(OutFullScale * 256);

  localparam logic [19:0] CoefA [2] = '{20'd765511, 20'd847436};
  localparam logic [30:0] CoefB [2] = '{31'd1254179929, 31'd1388397313};
  localparam logic [23:0] CoefC [2] = '{24'd1808410, 24'd2001946};

  localparam logic [0:0] CfgThreshold = 1'b0;
  localparam logic [0:0] CfgIdleLimit = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic signed [15:0] left_x_raw;
    logic signed [15:0] left_y_raw;
    logic signed [15:0] right_x_raw;
    logic signed [15:0] right_y_raw;
    logic [7:0]        left_trigger_raw;
    logic [7:0]        right_trigger_raw;
    logic              pad_present;
    logic [15:0]       idle_ms;
    logic [31:0]       pause_time_ms;
    logic [7:0]        rumble_freq;
    logic [14:0]       rumble_duration;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] left_x_out;
    logic signed [7:0] left_y_out;
    logic signed [7:0] right_x_out;
    logic signed [7:0] right_y_out;
    logic [7:0]        left_trigger_out;
    logic [7:0]        right_trigger_out;
    logic [15:0]       motor_level;
    logic [14:0]       rumble_remaining;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RAD_SQ, ST_RAD_A, ST_RAD_AH, ST_RAD_B, ST_RAD_SUM, ST_SHAPE, ST_DIV,
    ST_DIV_END, ST_TRIG, ST_TRIG_DIV, ST_TRIG_END, ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [48:0] dividend;
    logic [23:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [48:0] quot;
  } div_rsp_t;

endpackage

### rtl/gstc_divider.sv
// Shared restoring divider, one quotient bit per cycle.
module gstc_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  gstc_pkg::div_req_t req,
  output gstc_pkg::div_rsp_t rsp
);

  logic [48:0] q_r, q_nxt;
  logic [24:0] rem_r, rem_nxt;
  logic [23:0] dv_r, dv_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [24:0] trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; dv_nxt = dv_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r[23:0], q_r[48]};
    if (req.start) begin
      q_nxt = req.dividend; rem_nxt = '0; dv_nxt = req.divisor;
      cnt_nxt = 6'd49; busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract when it fits
      if (trial >= {1'b0, dv_r}) begin
        rem_nxt = trial - {1'b0, dv_r};
        q_nxt = {q_r[47:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[47:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; dv_r <= dv_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = q_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("done without busy");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start) else $error("divider restarted while busy");
  a_cnt_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> cnt_r == 6'd0) else $error("count not clear when idle");

endmodule

### rtl/gamepad_stick_trigger_conditioner.sv
// Top level: sequenced stick deadzone, trigger scaling and rumble control.
// A rumble request's result is offered in the cycle after acceptance; a poll's length depends
// on which axes leave their deadzone and which triggers exceed the threshold, since each of
// those divides on the shared 49-step divider; every axis also uses the radius multiplier.
// Throughput: one item at a time; in_ready returns the cycle after the result is taken.
// Reset (rst_n low, synchronous) restores threshold 30, idle limit 20000, clears the rumble.
module gamepad_stick_trigger_conditioner (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  gstc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output gstc_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  gstc_pkg::state_t state_r, state_nxt;
  gstc_pkg::in_item_t item_r;
  gstc_pkg::out_item_t res_r, res_nxt;
  gstc_pkg::div_req_t dreq;
  gstc_pkg::div_rsp_t drsp;

  logic [7:0]  thr_r;
  logic [15:0] idle_lim_r;
  logic [7:0]  strength_r, strength_nxt;
  logic [15:0] tleft_r, tleft_nxt;
  logic [31:0] stamp_r, stamp_nxt;

  // axis step: 0 LX, 1 LY, 2 RX, 3 RY; trigger step: 0 left, 1 right
  logic [1:0]  axis_r, axis_nxt;
  logic [23:0] mag_r, mag_nxt;     // magnitude fed to the radius
  logic [47:0] prod_r, prod_nxt;   // shared multiplier output
  logic [39:0] sq_r, sq_nxt;       // low half of the squared term times A
  logic [23:0] ta_r, ta_nxt;
  logic [23:0] dz_r, dz_nxt;
  logic [23:0] cmag_r, cmag_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [63:0] a_sum;
  logic        side;
  logic [15:0] raw_sel;
  logic [23:0] m_self;
  logic [7:0]  tsel, tv;
  logic [7:0]  axis_val;
  logic        neg;
  logic        active;
  logic [15:0] w;

  assign side = axis_r[1];
  assign mul_p = 64'(mul_a) * 64'(mul_b);
  // square term times A, split as high and low 20-bit halves of the square
  assign a_sum = {4'd0, mul_p[39:0], 20'd0} + {24'd0, sq_r};

  always_comb begin
    case (axis_r)
      2'd0: raw_sel = item_r.left_x_raw;
      2'd1: raw_sel = item_r.left_y_raw;
      2'd2: raw_sel = item_r.right_x_raw;
      default: raw_sel = item_r.right_y_raw;
    endcase
  end

  function automatic logic [23:0] mag_of(input logic [15:0] r);
    logic [15:0] a;
    a = r[15] ? (16'd0 - r) : r;
    mag_of = (r == 16'h8000) ? 24'h800000 : {a, 8'd0};
  endfunction

  assign m_self = mag_of(raw_sel);
  assign neg = raw_sel[15];
  assign tsel = axis_r[0] ? item_r.right_trigger_raw : item_r.left_trigger_raw;

  // rumble decision for the poll being finished
  assign active = item_r.pad_present && (item_r.idle_ms <= idle_lim_r) &&
                  strength_r != 8'd0 && tleft_r != 16'd0;
  assign w = tleft_r - 16'(item_r.pause_time_ms - stamp_r);

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0; mul_b = '0;
    case (state_r)
      gstc_pkg::ST_RAD_SQ: begin mul_a = 32'(mag_r); mul_b = 32'(mag_r); end
      gstc_pkg::ST_RAD_A: begin
        mul_a = 32'(prod_r[27:8]); mul_b = 32'(gstc_pkg::CoefA[side]);
      end
      gstc_pkg::ST_RAD_AH: begin
        mul_a = 32'(prod_r[47:28]); mul_b = 32'(gstc_pkg::CoefA[side]);
      end
      gstc_pkg::ST_RAD_B: begin
        mul_a = 32'(mag_r); mul_b = 32'(gstc_pkg::CoefB[side]);
      end
      gstc_pkg::ST_SHAPE: begin
        mul_a = 32'(m_self - dz_r); mul_b = 32'(gstc_pkg::ScaleNum);
      end
      gstc_pkg::ST_TRIG: begin
        mul_a = 32'(tsel - thr_r); mul_b = 32'd255;
      end
      default: ;
    endcase
  end

  // output magnitude clamp and sign
  function automatic logic [7:0] to_out(input logic [23:0] m, input logic n);
    logic [23:0] c;
    logic [7:0]  v;
    c = (m > gstc_pkg::OutLimQ) ? gstc_pkg::OutLimQ : m;
    v = c[15:8];
    to_out = n ? (8'd0 - v) : v;
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gstc_pkg::ST_IDLE:
        if (in_valid) state_nxt = in_data.req_type ? gstc_pkg::ST_OUT : gstc_pkg::ST_RAD_SQ;
      gstc_pkg::ST_RAD_SQ:  state_nxt = gstc_pkg::ST_RAD_A;
      gstc_pkg::ST_RAD_A:   state_nxt = gstc_pkg::ST_RAD_AH;
      gstc_pkg::ST_RAD_AH:  state_nxt = gstc_pkg::ST_RAD_B;
      gstc_pkg::ST_RAD_B:   state_nxt = gstc_pkg::ST_RAD_SUM;
      gstc_pkg::ST_RAD_SUM: state_nxt = gstc_pkg::ST_SHAPE;
      gstc_pkg::ST_SHAPE:
        if (m_self <= dz_r || gstc_pkg::FullQ <= dz_r) begin
          state_nxt = (axis_r == 2'd3) ? gstc_pkg::ST_TRIG : gstc_pkg::ST_RAD_SQ;
        end else begin
          state_nxt = gstc_pkg::ST_DIV;
        end
      gstc_pkg::ST_DIV:     if (drsp.done) state_nxt = gstc_pkg::ST_DIV_END;
      gstc_pkg::ST_DIV_END:
        state_nxt = (axis_r == 2'd3) ? gstc_pkg::ST_TRIG : gstc_pkg::ST_RAD_SQ;
      gstc_pkg::ST_TRIG:
        if (tsel <= thr_r) begin
          state_nxt = axis_r[0] ? gstc_pkg::ST_OUT : gstc_pkg::ST_TRIG;
        end else begin
          state_nxt = gstc_pkg::ST_TRIG_DIV;
        end
      gstc_pkg::ST_TRIG_DIV: if (drsp.done) state_nxt = gstc_pkg::ST_TRIG_END;
      gstc_pkg::ST_TRIG_END:
        state_nxt = axis_r[0] ? gstc_pkg::ST_OUT : gstc_pkg::ST_TRIG;
      gstc_pkg::ST_OUT:     if (out_ready) state_nxt = gstc_pkg::ST_IDLE;
      default:              state_nxt = gstc_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    axis_nxt = axis_r; mag_nxt = mag_r; prod_nxt = prod_r;
    sq_nxt = sq_r; ta_nxt = ta_r; dz_nxt = dz_r; cmag_nxt = cmag_r;
    res_nxt = res_r;
    strength_nxt = strength_r; tleft_nxt = tleft_r; stamp_nxt = stamp_r;
    dreq = '0;
    cmag_nxt = cmag_r;
    axis_val = '0;
    tv = '0;
    case (state_r)
      gstc_pkg::ST_IDLE:
        if (in_valid) begin
          axis_nxt = 2'd0;
          mag_nxt = mag_of(in_data.left_y_raw);
          res_nxt = '0;
          if (in_data.req_type) begin
            // load rumble, result reports only the duration
            strength_nxt = in_data.rumble_freq;
            tleft_nxt = {1'b0, in_data.rumble_duration};
            res_nxt.rumble_remaining = in_data.rumble_duration;
          end
        end
      gstc_pkg::ST_RAD_SQ: prod_nxt = mul_p[47:0];
      gstc_pkg::ST_RAD_A: sq_nxt = mul_p[39:0];
      gstc_pkg::ST_RAD_AH: ta_nxt = a_sum[63:40];
      gstc_pkg::ST_RAD_B: prod_nxt = {24'd0, mul_p[63:40]};
      gstc_pkg::ST_RAD_SUM:
        dz_nxt = ta_r + prod_r[23:0] + gstc_pkg::CoefC[side];
      gstc_pkg::ST_SHAPE: begin
        prod_nxt = mul_p[47:0];
        if (m_self <= dz_r) cmag_nxt = '0;
        else if (gstc_pkg::FullQ <= dz_r) cmag_nxt = gstc_pkg::MagMax;
        else begin
          dreq.start = 1'b1;
          dreq.dividend = 49'(mul_p);
          dreq.divisor = gstc_pkg::FullQ - dz_r;
        end
        if (m_self <= dz_r || gstc_pkg::FullQ <= dz_r) begin
          axis_val = to_out(cmag_nxt, neg);
        end
      end
      gstc_pkg::ST_DIV_END: begin
        cmag_nxt = (drsp.quot > 49'(gstc_pkg::MagMax)) ? gstc_pkg::MagMax : drsp.quot[23:0];
        axis_val = to_out(cmag_nxt, neg);
      end
      gstc_pkg::ST_TRIG: begin
        if (tsel <= thr_r) tv = '0;
        else begin
          dreq.start = 1'b1;
          dreq.dividend = 49'(mul_p[15:0]);
          dreq.divisor = 24'(8'd255 - thr_r);
        end
      end
      gstc_pkg::ST_TRIG_END: tv = drsp.quot[7:0];
      default: ;
    endcase

    // commit axis results: X feeds the Y radius with its magnitude
    if ((state_r == gstc_pkg::ST_SHAPE && state_nxt != gstc_pkg::ST_DIV) ||
        state_r == gstc_pkg::ST_DIV_END) begin
      case (axis_r)
        2'd0: res_nxt.left_x_out = axis_val;
        2'd1: res_nxt.left_y_out = axis_val;
        2'd2: res_nxt.right_x_out = axis_val;
        default: res_nxt.right_y_out = axis_val;
      endcase
      axis_nxt = axis_r + 2'd1;
      mag_nxt = axis_r[0] ? mag_of(item_r.right_y_raw) : cmag_nxt;
      if (axis_r == 2'd3) axis_nxt = 2'd0;
    end

    if ((state_r == gstc_pkg::ST_TRIG && tsel <= thr_r) ||
        state_r == gstc_pkg::ST_TRIG_END) begin
      if (axis_r[0]) res_nxt.right_trigger_out = tv;
      else res_nxt.left_trigger_out = tv;
      axis_nxt = 2'd1;
      if (axis_r[0]) begin
        // rumble update on the last cycle of the poll
        res_nxt.motor_level = '0;
        if (active) begin
          res_nxt.motor_level = {strength_r, strength_r};
          if (stamp_r != 32'd0) begin
            if (w == 16'd0 || w[15]) begin
              tleft_nxt = '0; stamp_nxt = '0; res_nxt.motor_level = '0;
            end else begin
              tleft_nxt = w; stamp_nxt = item_r.pause_time_ms;
            end
          end else begin
            stamp_nxt = item_r.pause_time_ms;
          end
        end else begin
          if ((!item_r.pad_present || item_r.idle_ms > idle_lim_r) && strength_r != 8'd0) begin
            strength_nxt = '0; tleft_nxt = '0;
          end
          stamp_nxt = '0;
        end
        res_nxt.rumble_remaining = tleft_nxt[14:0];
      end
    end
    if (state_r == gstc_pkg::ST_SHAPE && axis_r == 2'd3 && state_nxt == gstc_pkg::ST_TRIG)
      axis_nxt = 2'd0;
    if (state_r == gstc_pkg::ST_DIV_END && axis_r == 2'd3) axis_nxt = 2'd0;
  end

  assign in_ready  = (state_r == gstc_pkg::ST_IDLE);
  assign out_valid = (state_r == gstc_pkg::ST_OUT);
  assign out_data  = res_r;

  gstc_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gstc_pkg::ST_IDLE;
      thr_r <= 8'd30;
      idle_lim_r <= 16'd20000;
      strength_r <= '0; tleft_r <= '0; stamp_r <= '0; axis_r <= '0;
    end else begin
      state_r <= state_nxt;
      strength_r <= strength_nxt; tleft_r <= tleft_nxt; stamp_r <= stamp_nxt;
      axis_r <= axis_nxt;
      if (cfg_we) begin
        if (cfg_index == gstc_pkg::CfgThreshold) thr_r <= cfg_data[7:0];
        else idle_lim_r <= cfg_data;
      end
    end
    if (state_r == gstc_pkg::ST_IDLE && in_valid) item_r <= in_data;
    mag_r <= mag_nxt; prod_r <= prod_nxt; sq_r <= sq_nxt;
    ta_r <= ta_nxt; dz_r <= dz_nxt; cmag_r <= cmag_nxt; res_r <= res_nxt;
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> state_r != gstc_pkg::ST_IDLE) else $error("ready while busy");
  a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.busy |-> (state_r == gstc_pkg::ST_DIV || state_r == gstc_pkg::ST_TRIG_DIV))
    else $error("divider running outside a division step");

endmodule
